FILE: rtl/tdpt_pkg.sv
package tdpt_pkg;

	localparam int unsigned FIELD_W   = 16;
	localparam int unsigned OUT_DATA_W = 40;
	localparam logic [FIELD_W-1:0] TALLY_MAX = 16'hFFFF;

	// controller to datapath
	typedef struct packed {
		logic load;       // take a new candidate, start at divisor two
		logic div_start;  // prime the remainder unit
		logic div_step;   // one restoring step
		logic next_div;   // advance divisor and its square
		logic found;      // exact division seen
		logic result_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic sq_gt_n;
		logic div_last;
		logic rem_zero;
		logic out_full;
	} sts_t;

endpackage

FILE: rtl/trial_division_prime_test.sv
// Each trial divisor goes through a check, a bit-serial remainder pass over
// NUM_WIDTH bits and an evaluation; the result then loads in the done state and
// drives m_axis_tvalid. The remainder unit yields one quotient bit per cycle.
// Flow: one candidate at a time, the next accepted in the cycle after the result
// loads; 65521 tries 254 divisors.
// Reset: arst_n asynchronous, clears the controller, the output valid and the
// prime count.
module trial_division_prime_test #(
	parameter int unsigned NUM_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [15:0] candidate
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata    // [0] is_prime, [16:1] smallest_divisor,
	                                    // [32:17] primes_so_far, [39:33] zero
);
	import tdpt_pkg::*;

	cmd_t cmd;
	sts_t sts;

	tdpt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tdpt_dpath #(
		.NUM_WIDTH (NUM_WIDTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.candidate (s_axis_tdata),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

endmodule

FILE: rtl/tdpt_ctrl.sv
module tdpt_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  tdpt_pkg::sts_t  sts,
	output tdpt_pkg::cmd_t  cmd
);
	import tdpt_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CHECK = 3'd1;
	localparam logic [2:0] ST_DIV   = 3'd2;
	localparam logic [2:0] ST_EVAL  = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				// divisor squared past the candidate: no divisor left to try
				if (sts.sq_gt_n) begin
					state_d = ST_DONE;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (sts.rem_zero) begin
					cmd.found = 1'b1;
					state_d   = ST_DONE;
				end else begin
					cmd.next_div = 1'b1;
					state_d      = ST_CHECK;
				end
			end
			ST_DONE: begin
				// hold until the output register is free
				if (!sts.out_full) begin
					cmd.result_load = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

FILE: rtl/tdpt_dpath.sv
module tdpt_dpath #(
	parameter int unsigned NUM_WIDTH = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [tdpt_pkg::FIELD_W-1:0]       candidate,
	input  tdpt_pkg::cmd_t                     cmd,
	output tdpt_pkg::sts_t                     sts,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [tdpt_pkg::OUT_DATA_W-1:0]    out_data
);
	import tdpt_pkg::*;

	localparam int unsigned W    = NUM_WIDTH;
	localparam int unsigned SQW  = W + 2;
	localparam int unsigned CNTW = $clog2(W);
	localparam int unsigned EXW  = (W > FIELD_W) ? W : FIELD_W;

	logic [W-1:0]        n_q;
	logic [W-1:0]        d_q;
	logic [SQW-1:0]      sq_q;
	logic [W-1:0]        rem_q;
	logic [W-1:0]        nsh_q;
	logic [CNTW-1:0]     cnt_q;
	logic                found_q;
	logic [FIELD_W-1:0]  tally_q;
	logic                out_valid_q;
	logic                res_prime_q;
	logic [FIELD_W-1:0]  res_div_q;

	logic [EXW-1:0]      cand_ext;
	logic [EXW-1:0]      d_ext;
	logic [W:0]          trial;
	logic                trial_ge;
	logic                prime;
	logic [FIELD_W-1:0]  tally_next;

	assign cand_ext = EXW'(candidate);
	assign d_ext    = EXW'(d_q);

	// restoring remainder step
	assign trial    = {rem_q, nsh_q[W-1]};
	assign trial_ge = trial >= {1'b0, d_q};

	assign prime      = !found_q && (n_q >= W'(2));
	assign tally_next = (prime && tally_q != TALLY_MAX) ? tally_q + 1'b1 : tally_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q  <= cand_ext[W-1:0];
			d_q  <= W'(2);
			sq_q <= SQW'(4);
		end else if (cmd.next_div) begin
			d_q  <= d_q + 1'b1;
			sq_q <= sq_q + {1'b0, d_q, 1'b0} + 1'b1;
		end
		if (cmd.div_start) begin
			rem_q <= '0;
			nsh_q <= n_q;
			cnt_q <= CNTW'(W - 1);
		end else if (cmd.div_step) begin
			rem_q <= trial_ge ? trial[W-1:0] - d_q : trial[W-1:0];
			nsh_q <= {nsh_q[W-2:0], 1'b0};
			cnt_q <= cnt_q - 1'b1;
		end
		if (cmd.result_load) begin
			res_prime_q <= prime;
			res_div_q   <= found_q ? d_ext[FIELD_W-1:0] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q     <= 1'b0;
			tally_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				found_q <= 1'b0;
			end else if (cmd.found) begin
				found_q <= 1'b1;
			end
			if (cmd.result_load) begin
				tally_q     <= tally_next;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.sq_gt_n  = sq_q > SQW'(n_q);
	assign sts.div_last = (cnt_q == '0);
	assign sts.rem_zero = (rem_q == '0);
	assign sts.out_full = out_valid_q && !out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = {7'd0, tally_q, res_div_q, res_prime_q};

endmodule
